### design/tlsrs_pkg.sv
// ----------------------------------------------------------------------------
// tlsrs_pkg
// Shared types and constants of the TLS transmit resync tracker.
// ----------------------------------------------------------------------------
package tlsrs_pkg;

  localparam int unsigned SeqW  = 32;
  localparam int unsigned LenW  = 16;
  localparam int unsigned RecW  = 64;
  localparam int unsigned MssW  = 14;
  localparam int unsigned OffW  = 15;
  localparam int unsigned KindW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [KindW-1:0] {
    KindPass   = 3'd0,
    KindAttach = 3'd1,
    KindResync = 3'd2,
    KindFence  = 3'd3,
    KindChunk  = 3'd4,
    KindError  = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTlsEnabled    = 2'd0,
    CfgMss           = 2'd1,
    CfgStartSeqno    = 2'd2,
    CfgStartRecordSeq = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SeqW-1:0] seg_seqno;
    logic [LenW-1:0] seg_len;
    logic            offloaded_payload;
    logic [SeqW-1:0] record_start_seqno;
    logic [RecW-1:0] tls_rec_num;
  } seg_t;

  typedef struct packed {
    kind_e           kind;
    logic [RecW-1:0] resync_record;
    logic            rec_match;
    logic [OffW-1:0] chunk_offset;
    logic [MssW-1:0] chunk_len;
    logic            chunk_first;
    logic            attach_context;
    logic            last;
  } result_t;

  // one step of the chunk cutter
  typedef struct packed {
    logic [MssW-1:0] len;
    logic            last;
  } chunk_step_t;

endpackage

### design/tlsrs_chunk_unit.sv
// ----------------------------------------------------------------------------
// tlsrs_chunk_unit
// Shared compare/subtract/add step that cuts one replay chunk off the
// remaining record bytes and advances the record offset.
// ----------------------------------------------------------------------------
module tlsrs_chunk_unit #(
  parameter int unsigned RemW = 15
) (
  input  logic [RemW-1:0]              rem_i,
  input  logic [RemW-1:0]              off_i,
  input  logic [tlsrs_pkg::MssW-1:0]   mss_i,
  output logic [RemW-1:0]              rem_o,
  output logic [RemW-1:0]              off_o,
  output tlsrs_pkg::chunk_step_t       step_o
);

  localparam int unsigned ExtW = RemW + tlsrs_pkg::MssW;

  logic [ExtW-1:0] rem_ext;
  logic [ExtW-1:0] mss_ext;
  logic [ExtW-1:0] off_ext;
  logic [ExtW-1:0] rem_sub;
  logic [ExtW-1:0] off_add;

  assign rem_ext = {{tlsrs_pkg::MssW{1'b0}}, rem_i};
  assign off_ext = {{tlsrs_pkg::MssW{1'b0}}, off_i};
  assign mss_ext = {{RemW{1'b0}}, mss_i};
  assign rem_sub = rem_ext - mss_ext;
  assign off_add = off_ext + mss_ext;

  always_comb begin
    step_o.last = (rem_ext <= mss_ext);
    // last chunk takes what is left, which never exceeds mss
    step_o.len  = step_o.last ? rem_ext[tlsrs_pkg::MssW-1:0] : mss_i;
    rem_o       = rem_sub[RemW-1:0];
    off_o       = off_add[RemW-1:0];
  end

endmodule

### design/tls_tx_resync_tracker_core.sv
// ----------------------------------------------------------------------------
// tls_tx_resync_tracker_core
// Tracks the expected TCP sequence number of a TLS transmit offload context
// and turns out-of-order segments into resync, fence and replay chunk beats.
// ----------------------------------------------------------------------------
// Usage:
//   One segment beat enters on in_valid_i/in_stall_o with in_data_i; the
//   results leave on out_valid_o/out_stall_i with out_data_o, the final beat
//   of a segment marked by last. Configuration must be written through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle; the block
//   does not enforce it. Writing the start sequence or start record sequence
//   reloads the tracking state at once. After a segment beat is taken,
//   in_stall_o stays high until its last result is loaded into the output
//   register; the first comes from the decision state that follows the beat.
//   A resync sends a resync result, N replay chunks or one fence, then an
//   attach result, one result a cycle while the output is not stalled, all
//   through a single shared chunk step unit. The output register holds a
//   stalled beat and the sequencer waits for it. The block can take the next
//   segment while the last result still sits in the output register. Reset
//   empties the output, returns to idle and loads the register defaults
//   (disabled, mss 1460, sequence and record sequence zero).
// ----------------------------------------------------------------------------
module tls_tx_resync_tracker_core #(
  parameter int unsigned MAX_RECORD_BYTES = 16413,
  parameter int unsigned MAX_CHUNKS       = 31
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlsrs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tlsrs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tlsrs_pkg::seg_t                  in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tlsrs_pkg::result_t               out_data_o
);

  localparam int unsigned RemW = $clog2(MAX_RECORD_BYTES + 1);
  localparam int unsigned ChW  = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned LimW = ChW + tlsrs_pkg::MssW;
  localparam int unsigned OffExtW = RemW + tlsrs_pkg::OffW;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StDecide = 4'b0010,
    StBody   = 4'b0100,
    StAttach = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration and tracking state
  logic                         tls_en_q;
  logic [tlsrs_pkg::MssW-1:0]   mss_q;
  logic [tlsrs_pkg::SeqW-1:0]   exp_seq_q, exp_seq_d;
  logic [tlsrs_pkg::RecW-1:0]   ctx_rec_q, ctx_rec_d;

  // captured segment
  tlsrs_pkg::seg_t              seg_q;
  logic [RemW-1:0]              dist_q;
  logic                         dist_ok_q;

  // chunk walk
  logic [RemW-1:0]              rem_q, rem_d;
  logic [RemW-1:0]              off_q, off_d;
  logic [RemW-1:0]              rem_nxt, off_nxt;
  tlsrs_pkg::chunk_step_t       step;

  logic                         out_valid_q, out_valid_d;
  tlsrs_pkg::result_t           out_data_q, out_data_d;

  logic                         in_acc;
  logic                         slot_free;
  logic                         emit;
  logic [tlsrs_pkg::SeqW-1:0]   dist_full;
  logic [LimW-1:0]              chunk_lim;
  logic                         too_many;
  logic                         pass_seg;
  logic [OffExtW-1:0]           off_ext;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign dist_full = in_data_i.seg_seqno - in_data_i.record_start_seqno;
  assign chunk_lim = LimW'(MAX_CHUNKS) * LimW'(mss_q);
  assign too_many  = (32'(dist_q) > 32'(chunk_lim));
  assign pass_seg  = !tls_en_q || !seg_q.offloaded_payload || (seg_q.seg_len == '0);
  assign off_ext   = {{tlsrs_pkg::OffW{1'b0}}, off_q};

  tlsrs_chunk_unit #(
    .RemW (RemW)
  ) u_chunk (
    .rem_i  (rem_q),
    .off_i  (off_q),
    .mss_i  (mss_q),
    .rem_o  (rem_nxt),
    .off_o  (off_nxt),
    .step_o (step)
  );

  always_comb begin
    state_d    = state_q;
    exp_seq_d  = exp_seq_q;
    ctx_rec_d  = ctx_rec_q;
    rem_d      = rem_q;
    off_d      = off_q;
    emit       = 1'b0;
    out_data_d = '0;
    out_data_d.kind = tlsrs_pkg::KindPass;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (slot_free) begin
          emit = 1'b1;
          if (pass_seg) begin
            out_data_d.kind = tlsrs_pkg::KindPass;
            out_data_d.last = 1'b1;
            state_d         = StIdle;
          end else if (seg_q.seg_seqno == exp_seq_q) begin
            out_data_d.kind           = tlsrs_pkg::KindAttach;
            out_data_d.attach_context = 1'b1;
            out_data_d.last           = 1'b1;
            exp_seq_d = exp_seq_q + tlsrs_pkg::SeqW'(seg_q.seg_len);
            state_d   = StIdle;
          end else if (!dist_ok_q || (mss_q == '0) || too_many) begin
            out_data_d.kind = tlsrs_pkg::KindError;
            out_data_d.last = 1'b1;
            state_d         = StIdle;
          end else begin
            out_data_d.kind          = tlsrs_pkg::KindResync;
            out_data_d.resync_record = seg_q.tls_rec_num;
            out_data_d.rec_match     = (ctx_rec_q == seg_q.tls_rec_num);
            ctx_rec_d = seg_q.tls_rec_num;
            rem_d     = dist_q;
            off_d     = '0;
            state_d   = StBody;
          end
        end
      end
      StBody: begin
        if (slot_free) begin
          emit = 1'b1;
          if (dist_q == '0) begin
            out_data_d.kind = tlsrs_pkg::KindFence;
            state_d         = StAttach;
          end else begin
            out_data_d.kind         = tlsrs_pkg::KindChunk;
            out_data_d.chunk_offset = off_ext[tlsrs_pkg::OffW-1:0];
            out_data_d.chunk_len    = step.len;
            out_data_d.chunk_first  = (off_q == '0);
            rem_d = rem_nxt;
            off_d = off_nxt;
            if (step.last) begin
              state_d = StAttach;
            end
          end
        end
      end
      StAttach: begin
        if (slot_free) begin
          emit = 1'b1;
          out_data_d.kind           = tlsrs_pkg::KindAttach;
          out_data_d.attach_context = 1'b1;
          out_data_d.last           = 1'b1;
          exp_seq_d = seg_q.seg_seqno + tlsrs_pkg::SeqW'(seg_q.seg_len);
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // config writes must only come while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tlsrs_pkg::CfgStartSeqno:     exp_seq_d = cfg_wdata_i[tlsrs_pkg::SeqW-1:0];
        tlsrs_pkg::CfgStartRecordSeq: ctx_rec_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      tls_en_q    <= 1'b0;
      mss_q       <= tlsrs_pkg::MssW'(1460);
      exp_seq_q   <= '0;
      ctx_rec_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      exp_seq_q   <= exp_seq_d;
      ctx_rec_q   <= ctx_rec_d;
      if (cfg_we_i && (cfg_idx_i == tlsrs_pkg::CfgTlsEnabled)) begin
        tls_en_q <= cfg_wdata_i[0];
      end
      if (cfg_we_i && (cfg_idx_i == tlsrs_pkg::CfgMss)) begin
        mss_q <= cfg_wdata_i[tlsrs_pkg::MssW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seg_q     <= in_data_i;
      dist_q    <= dist_full[RemW-1:0];
      dist_ok_q <= (dist_full <= tlsrs_pkg::SeqW'(MAX_RECORD_BYTES));
    end
    if (emit) begin
      out_data_q <= out_data_d;
    end
    rem_q <= rem_d;
    off_q <= off_d;
  end

  // a segment beat always leads into the decision step
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StDecide))
    else $error("segment beat not followed by decision step");

  // the last result of a segment frees the input side
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_data_d.last) |=> (state_q == StIdle))
    else $error("sequencer busy after last result");

  // a resync result loads the record number into the context
  a_resync_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (out_data_d.kind == tlsrs_pkg::KindResync)) |=> (ctx_rec_q == seg_q.tls_rec_num))
    else $error("context record not updated on resync");

  // only the opening chunk sits at offset zero
  a_chunk_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (out_data_d.kind == tlsrs_pkg::KindChunk) && !out_data_d.chunk_first)
      |-> (off_q != '0))
    else $error("later chunk at record start");

  // no result is loaded over a stalled beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_data_q))
    else $error("stalled result overwritten");

endmodule

### dv/tls_tx_resync_tracker_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tls_tx_resync_tracker_core_checker
// Watches the register port and both beat channels of the resync tracker,
// predicts the result beats of every accepted segment and compares them in
// order, field by field.
// ----------------------------------------------------------------------------
module tls_tx_resync_tracker_core_checker #(
  parameter int unsigned MAX_RECORD_BYTES = 16413,
  parameter int unsigned MAX_CHUNKS       = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlsrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlsrs_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  tlsrs_pkg::seg_t                in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  tlsrs_pkg::result_t             out_data_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_count_o,
  output int unsigned                    beat_count_o,
  output int unsigned                    resync_count_o,
  output int unsigned                    chunk_count_o
);

  logic                       enabled;
  logic [tlsrs_pkg::MssW-1:0] mss;
  logic [tlsrs_pkg::SeqW-1:0] expected_seqno;
  logic [tlsrs_pkg::RecW-1:0] context_rec;

  tlsrs_pkg::result_t pending_results[$];
  tlsrs_pkg::result_t want;
  int unsigned        mismatches, beats, resyncs, chunks;

  function automatic tlsrs_pkg::result_t blank_result(tlsrs_pkg::kind_e k, logic is_last);
    tlsrs_pkg::result_t r;
    r      = '0;
    r.kind = k;
    r.last = is_last;
    return r;
  endfunction

  function automatic string describe(tlsrs_pkg::result_t r);
    return $sformatf("kind %0d rec %h match %0d off %0d len %0d first %0d attach %0d last %0d",
                     r.kind, r.resync_record, r.rec_match, r.chunk_offset, r.chunk_len,
                     r.chunk_first, r.attach_context, r.last);
  endfunction

  // push the result beats one segment causes and advance the tracking state
  function automatic void predict_segment(tlsrs_pkg::seg_t s);
    tlsrs_pkg::result_t         r;
    logic [tlsrs_pkg::SeqW-1:0] span;
    int unsigned                nchunks, clen, rem;
    if (!enabled || !s.offloaded_payload || s.seg_len == '0) begin
      pending_results.push_back(blank_result(tlsrs_pkg::KindPass, 1'b1));
    end else if (s.seg_seqno == expected_seqno) begin
      expected_seqno = expected_seqno + tlsrs_pkg::SeqW'(s.seg_len);
      r = blank_result(tlsrs_pkg::KindAttach, 1'b1);
      r.attach_context = 1'b1;
      pending_results.push_back(r);
    end else begin
      // distance into the record, modulo 2^32
      span = s.seg_seqno - s.record_start_seqno;
      if (mss == '0 || span > MAX_RECORD_BYTES) begin
        pending_results.push_back(blank_result(tlsrs_pkg::KindError, 1'b1));
      end else begin
        nchunks = (int'(span) + int'(mss) - 1) / int'(mss);
        if (nchunks > MAX_CHUNKS) begin
          pending_results.push_back(blank_result(tlsrs_pkg::KindError, 1'b1));
        end else begin
          r = blank_result(tlsrs_pkg::KindResync, 1'b0);
          r.resync_record = s.tls_rec_num;
          r.rec_match     = (context_rec == s.tls_rec_num);
          context_rec     = s.tls_rec_num;
          pending_results.push_back(r);
          if (nchunks == 0) begin
            pending_results.push_back(blank_result(tlsrs_pkg::KindFence, 1'b0));
          end
          for (int unsigned i = 0; i < nchunks; i++) begin
            clen = int'(mss);
            if (i == nchunks - 1) begin
              rem  = int'(span) % int'(mss);
              clen = (rem == 0) ? int'(mss) : rem;
            end
            r = blank_result(tlsrs_pkg::KindChunk, 1'b0);
            r.chunk_offset = tlsrs_pkg::OffW'(i * mss);
            r.chunk_len    = tlsrs_pkg::MssW'(clen);
            r.chunk_first  = (i == 0);
            pending_results.push_back(r);
          end
          expected_seqno = s.seg_seqno + tlsrs_pkg::SeqW'(s.seg_len);
          r = blank_result(tlsrs_pkg::KindAttach, 1'b1);
          r.attach_context = 1'b1;
          pending_results.push_back(r);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled        = 1'b0;
      mss            = 14'd1460;
      expected_seqno = '0;
      context_rec    = '0;
      pending_results.delete();
      mismatches     = 0;
      beats          = 0;
      resyncs        = 0;
      chunks         = 0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (tlsrs_pkg::cfg_idx_e'(cfg_idx_i))
          tlsrs_pkg::CfgTlsEnabled:     enabled = cfg_wdata_i[0];
          tlsrs_pkg::CfgMss:            mss = cfg_wdata_i[tlsrs_pkg::MssW-1:0];
          tlsrs_pkg::CfgStartSeqno:     expected_seqno = cfg_wdata_i[tlsrs_pkg::SeqW-1:0];
          tlsrs_pkg::CfgStartRecordSeq: context_rec = cfg_wdata_i[tlsrs_pkg::RecW-1:0];
          default: ;
        endcase
      end
      // results of a segment never leave in its own acceptance cycle
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        beats++;
        if (out_data_i.kind == tlsrs_pkg::KindResync) resyncs++;
        if (out_data_i.kind == tlsrs_pkg::KindChunk) chunks++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result beat with no segment pending: %s", $time,
                     describe(out_data_i));
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_i.kind !== want.kind ||
              out_data_i.resync_record !== want.resync_record ||
              out_data_i.rec_match !== want.rec_match ||
              out_data_i.chunk_offset !== want.chunk_offset ||
              out_data_i.chunk_len !== want.chunk_len ||
              out_data_i.chunk_first !== want.chunk_first ||
              out_data_i.attach_context !== want.attach_context ||
              out_data_i.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: result beat mismatch", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(out_data_i));
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        predict_segment(in_data_i);
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= pending_results.size();
    beat_count_o     <= beats;
    resync_count_o   <= resyncs;
    chunk_count_o    <= chunks;
  end

endmodule

### dv/tls_tx_resync_tracker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tls_tx_resync_tracker_core_tb
// Drives segment beats and register settings into the resync tracker, with
// random idle bursts on both channels; a checker beside the block predicts
// and compares every result beat. Random, directed, then random segments.
// ----------------------------------------------------------------------------
module tls_tx_resync_tracker_core_tb;

  localparam int unsigned MaxRecordBytes = 16413;
  localparam int unsigned MaxChunks      = 31;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [tlsrs_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [tlsrs_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  tlsrs_pkg::seg_t                in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tlsrs_pkg::result_t             out_data;

  int unsigned mismatches, pending, beats, resyncs, chunks;

  logic                       idle_en = 1'b1;
  int unsigned                stall_left = 0;
  int unsigned                seg_count = 0;
  int unsigned                settings = 0;
  logic [tlsrs_pkg::MssW-1:0] cur_mss = 14'd1460;
  logic [tlsrs_pkg::SeqW-1:0] stream = '0;
  logic [tlsrs_pkg::RecW-1:0] cur_rec = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tls_tx_resync_tracker_core #(
    .MAX_RECORD_BYTES(MaxRecordBytes),
    .MAX_CHUNKS      (MaxChunks)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  tls_tx_resync_tracker_core_checker #(
    .MAX_RECORD_BYTES(MaxRecordBytes),
    .MAX_CHUNKS      (MaxChunks)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatches),
    .pending_count_o (pending),
    .beat_count_o    (beats),
    .resync_count_o  (resyncs),
    .chunk_count_o   (chunks)
  );

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic put_seg(tlsrs_pkg::seg_t s);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    seg_count++;
  endtask

  task automatic send_seg(logic [tlsrs_pkg::SeqW-1:0] seq, logic [tlsrs_pkg::LenW-1:0] len,
                          logic offl, logic [tlsrs_pkg::SeqW-1:0] rstart,
                          logic [tlsrs_pkg::RecW-1:0] rec);
    tlsrs_pkg::seg_t s;
    s.seg_seqno          = seq;
    s.seg_len            = len;
    s.offloaded_payload  = offl;
    s.record_start_seqno = rstart;
    s.tls_rec_num        = rec;
    put_seg(s);
  endtask

  // wait until every predicted beat has left, then let the block settle
  task automatic drain(int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(tlsrs_pkg::cfg_idx_e idx, logic [tlsrs_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(logic en, logic [tlsrs_pkg::MssW-1:0] m,
                               logic [tlsrs_pkg::SeqW-1:0] seq,
                               logic [tlsrs_pkg::RecW-1:0] rec);
    drain(4);
    write_reg(tlsrs_pkg::CfgTlsEnabled, tlsrs_pkg::CfgDataW'(en));
    write_reg(tlsrs_pkg::CfgMss, tlsrs_pkg::CfgDataW'(m));
    write_reg(tlsrs_pkg::CfgStartSeqno, tlsrs_pkg::CfgDataW'(seq));
    write_reg(tlsrs_pkg::CfgStartRecordSeq, rec);
    cfg_we  <= 1'b0;
    cur_mss = m;
    stream  = seq;
    cur_rec = rec;
    settings++;
  endtask

  // mostly in-order streams with valid resyncs, plus errors and pass-through noise
  function automatic tlsrs_pkg::seg_t random_segment();
    tlsrs_pkg::seg_t            s;
    int unsigned                pick, roll, cap;
    logic [tlsrs_pkg::SeqW-1:0] span;
    pick = $urandom_range(0, 99);
    roll = $urandom_range(0, 4);
    s.offloaded_payload = 1'b1;
    s.seg_len = ($urandom_range(0, 7) == 0) ? tlsrs_pkg::LenW'($urandom_range(1, 65535))
                                            : tlsrs_pkg::LenW'($urandom_range(1, 1460));
    s.tls_rec_num = (roll < 2) ? cur_rec : (roll < 4) ? cur_rec + 1 : {$urandom, $urandom};
    if (pick < 50) begin
      s.seg_seqno          = stream;
      s.record_start_seqno = stream - $urandom_range(0, MaxRecordBytes);
      stream               = stream + tlsrs_pkg::SeqW'(s.seg_len);
    end else if (pick < 75 && cur_mss != 0) begin
      cap = MaxChunks * cur_mss;
      if (cap > MaxRecordBytes) cap = MaxRecordBytes;
      span = ($urandom_range(0, 7) == 0) ? '0 : tlsrs_pkg::SeqW'($urandom_range(0, cap));
      s.seg_seqno          = stream + $urandom_range(1, 200000);
      s.record_start_seqno = s.seg_seqno - span;
      stream               = s.seg_seqno + tlsrs_pkg::SeqW'(s.seg_len);
      cur_rec              = s.tls_rec_num;
    end else if (pick < 88) begin
      if (cur_mss != 0 && cur_mss < 530 && $urandom_range(0, 1) == 0) begin
        span = $urandom_range(MaxChunks * cur_mss + 1, MaxRecordBytes);
      end else begin
        span = $urandom_range(MaxRecordBytes + 1, 32'hFFFF_FFFF);
      end
      s.seg_seqno          = stream + $urandom_range(1, 200000);
      s.record_start_seqno = s.seg_seqno - span;
    end else begin
      s.seg_seqno          = $urandom;
      s.record_start_seqno = $urandom;
      s.tls_rec_num        = {$urandom, $urandom};
      if (pick < 94) begin
        s.seg_len           = '0;
        s.offloaded_payload = 1'($urandom_range(0, 1));
      end else begin
        s.seg_len           = tlsrs_pkg::LenW'($urandom);
        s.offloaded_payload = 1'b0;
      end
    end
    return s;
  endfunction

  task automatic run_random(int unsigned n);
    repeat (n) put_seg(random_segment());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: offload off, everything passes
    run_random(3);

    load_settings(1'b1, 14'd1460, 32'hFFFF_FF00, 64'd5);
    send_seg(32'hFFFF_FF00, 16'h0100, 1'b1, 32'hFFFF_C000, 64'd5);  // in order, seq wraps
    send_seg(32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000, 64'd5);  // empty
    send_seg(32'h0000_0000, 16'd100, 1'b0, 32'h0000_0000, 64'd5);   // plain data
    send_seg(32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_0000, 64'd5);
    send_seg(32'h0002_0000, 16'd1000, 1'b1, 32'h0002_0000, 64'd5);  // fence
    send_seg(32'h0003_0001, 16'd200, 1'b1, 32'h0003_0000, 64'd6);   // one byte replay
    send_seg(32'h0004_05B4, 16'd300, 1'b1, 32'h0004_0000, 64'd6);   // exactly one mss
    send_seg(32'h0005_401D, 16'd1, 1'b1, 32'h0005_0000, '1);        // full record
    send_seg(32'h0006_401E, 16'd1, 1'b1, 32'h0006_0000, 64'd7);     // one byte too far
    send_seg(32'h0000_0005, 16'd10, 1'b1, 32'hFFFF_FFF0, 64'd7);    // distance wraps
    send_seg(32'h0000_0010, 16'd10, 1'b1, 32'h0000_0011, 64'd7);    // record start ahead
    send_seg(32'h0000_000F, 16'hFFFF, 1'b1, 32'h0000_0000, 64'd7);
    send_seg('1, '1, 1'b1, '1, '1);

    // small mss: exactly the chunk limit, then one chunk over
    load_settings(1'b1, 14'd512, 32'h0000_0100, 64'd0);
    send_seg(32'h0000_3E00, 16'd5, 1'b1, 32'h0000_0000, 64'd0);
    send_seg(32'h0001_3E01, 16'd5, 1'b1, 32'h0001_0000, 64'd1);

    load_settings(1'b1, 14'd0, 32'h0000_0000, 64'd0);
    send_seg(32'h0000_0000, 16'd8, 1'b1, 32'h0000_0000, 64'd0);
    send_seg(32'h0000_0064, 16'd8, 1'b1, 32'h0000_0064, 64'd0);     // mss zero

    load_settings(1'b1, 14'h3FFF, 32'h0000_1000, 64'd9);
    send_seg(32'h0000_5000, 16'd4, 1'b1, 32'h0000_0FE3, 64'd9);

    load_settings(1'b1, 14'd1460, $urandom, {$urandom, $urandom});
    run_random(25);
    load_settings(1'b1, 14'd536, 32'hFFFF_F000, '1);
    run_random(25);
    load_settings(1'b0, 14'd9000, $urandom, {$urandom, $urandom});
    run_random(15);
    load_settings(1'b1, 14'd9000, $urandom, {$urandom, $urandom});
    run_random(25);
    load_settings(1'b1, 14'd300, $urandom, {$urandom, $urandom});
    run_random(25);

    // closing stretch at full rate
    idle_en <= 1'b0;
    load_settings(1'b1, 14'd1460, $urandom, {$urandom, $urandom});
    run_random(25);

    drain(8);
    $display("sent %0d segments under %0d register settings, directed and random",
             seg_count, settings);
    $display("checked %0d result beats, %0d of them resyncs and %0d replay chunks",
             beats, resyncs, chunks);
    if (mismatches == 0 && pending == 0) begin
      $display("tls_tx_resync_tracker_core_tb passed");
    end else begin
      $display("tls_tx_resync_tracker_core_tb failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("tls_tx_resync_tracker_core_tb failed");
    $finish;
  end

endmodule

### sim.f
design/tlsrs_pkg.sv
design/tlsrs_chunk_unit.sv
design/tls_tx_resync_tracker_core.sv
dv/tls_tx_resync_tracker_core_checker.sv
dv/tls_tx_resync_tracker_core_tb.sv
